// File: hdl/point_light_binder_core_defines.svh
// Assertion macros shared by the light binder RTL.
`ifndef POINT_LIGHT_BINDER_CORE_DEFINES_SVH
`define POINT_LIGHT_BINDER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PLB_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PLB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

// File: hdl/plb_pkg.sv
// Types and constants of the point light binder.
package plb_pkg;
  localparam int unsigned MaxSlotsDef = 7;
  localparam int unsigned D2W = 42;   // squared distance, Q.8
  localparam int unsigned SW  = 32;   // isqrt of D2 << 16
  localparam int unsigned NumW = 37;  // |dx| * 30720

  typedef enum logic [1:0] {
    ST_BOUND = 2'd0,
    ST_SKIP  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_CMP, S_COL, S_SQRT, S_DIV, S_DONE
  } state_e;

  typedef struct packed {
    logic        func;
    logic        new_group;
    logic        position_valid;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic signed [15:0] radius;
    logic [23:0] color_rgb;
    logic signed [19:0] obj_x;
    logic signed [19:0] obj_y;
    logic signed [19:0] obj_z;
  } light_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic signed [7:0] dir_x;
    logic signed [7:0] dir_y;
    logic signed [7:0] dir_z;
  } bind_t;
endpackage

// File: hdl/plb_if.sv
// Valid/ready channel carrying one payload.
interface plb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/plb_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module plb_serial_mul #(
  parameter int unsigned AW = 8,
  parameter int unsigned BW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AW-1:0]        a_i,
  input  logic [BW-1:0]        b_i,
  output logic                 done_o,
  output logic [AW+BW-1:0]     p_o
);
  localparam int unsigned CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc_q, acc_d, a_q, a_d;
  logic [BW-1:0]    b_q, b_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;

  always_comb begin
    acc_d = acc_q; a_d = a_q; b_d = b_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      acc_d = '0; a_d = (AW+BW)'(a_i); b_d = b_i; cnt_d = CW'(BW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d = a_q << 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d;
  end

  // High in the cycle of the last step; the product is ready after this edge.
  assign done_o = busy_q && (cnt_q == CW'(1));
  assign p_o    = acc_q;
endmodule

// File: hdl/plb_serial_div.sv
// Restoring divider and square root, one quotient or root bit per cycle.
module plb_serial_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          sqrt_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] q_o
);
  localparam int unsigned CW = $clog2(NW + 1);
  localparam int unsigned RW = NW + 2;
  logic [NW-1:0] n_q, n_d, q_q, q_d;
  logic [RW-1:0] r_q, r_d, t;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          sq_q, sq_d, busy_q, busy_d;
  logic [RW-1:0] rem_sh;

  always_comb begin
    n_d = n_q; q_d = q_q; r_d = r_q; den_d = den_q; cnt_d = cnt_q;
    sq_d = sq_q; busy_d = busy_q; t = '0; rem_sh = '0;
    if (start_i) begin
      n_d = num_i; q_d = '0; r_d = '0; den_d = den_i; sq_d = sqrt_i;
      cnt_d = sqrt_i ? CW'(NW / 2) : CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (sq_q) begin
        rem_sh = {r_q[RW-3:0], n_q[NW-1:NW-2]};
        t = RW'({q_q[NW-3:0], 2'b01});
        n_d = n_q << 2;
      end else begin
        rem_sh = {r_q[RW-2:0], n_q[NW-1]};
        t = RW'(den_q);
        n_d = n_q << 1;
      end
      if (rem_sh >= t) begin
        r_d = rem_sh - t; q_d = {q_q[NW-2:0], 1'b1};
      end else begin
        r_d = rem_sh; q_d = {q_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    n_q <= n_d; q_q <= q_d; r_q <= r_d; den_q <= den_d; sq_q <= sq_d;
  end

  assign busy_o = busy_q;
  assign q_o    = q_q;
endmodule

// File: hdl/point_light_binder_core.sv
// Top level of the point light binder: sequencer and slot counter.
//
// The block binds one light per request to the next free slot of a group of
// at most MAX_SLOTS slots. Requests enter on in_i and each gives exactly one
// result on out_o; both are valid/ready channels that move a request at a
// clock edge where valid and ready are both high.
// Directional lights and point lights without a position are decided in S_CMP
// and present their result from S_DONE. A point light squares its three offsets
// and the radius in a shift-add multiplier; an out-of-range light or a full
// group then reports. A bound point light adds three colour scales (a multiply,
// then a restoring divide), a square root (skipped when the distance is below
// one) and three direction divides. One request is handled at a time. The
// result register holds its value while the receiver stalls, and the input
// stays blocked until the result has gone. Reset empties the group and clears
// the handshake state.
// Arithmetic is exact integer work: Q.8 squared distance, floored colour
// scale, truncated and saturated directions.
module point_light_binder_core #(
  parameter int unsigned MAX_SLOTS = plb_pkg::MaxSlotsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  plb_if.sink   in_i,
  plb_if.source out_o
);
  import plb_pkg::*;
  `include "point_light_binder_core_defines.svh"

  localparam int unsigned MW = 40;
  localparam int unsigned DivW = MW + 16;

  state_e state_q, state_d;
  light_t req_q;
  bind_t  res_q, res_d;
  logic   out_valid_q, out_valid_d;
  logic [2:0] slots_q, slots_d;
  logic [1:0] k_q, k_d;
  logic [D2W-1:0] d2_q, d2_d, r2_q, r2_d;
  logic [SW-1:0]  s_q, s_d;
  logic           sub_q, sub_d;

  logic signed [20:0] dx, dy, dz, dk;
  logic [20:0] mk;
  logic [19:0] rm;

  // shared serial units
  logic          mul_start;
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic          mul_done;
  logic [2*MW-1:0] mul_p;
  logic          div_start, div_sqrt, div_busy;
  logic [DivW-1:0] div_num;
  logic [MW-1:0] div_den;
  logic [DivW-1:0] div_q;
  logic [6:0]    mcnt_q, mcnt_d;

  plb_serial_mul #(.AW(MW), .BW(MW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );
  plb_serial_div #(.NW(DivW), .DW(MW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .sqrt_i(div_sqrt),
    .num_i(div_num), .den_i(div_den), .busy_o(div_busy), .q_o(div_q)
  );

  assign dx = 21'(signed'(req_q.light_x)) * 21'sd16 - 21'(req_q.obj_x);
  assign dy = 21'(signed'(req_q.light_y)) * 21'sd16 - 21'(req_q.obj_y);
  assign dz = 21'(signed'(req_q.light_z)) * 21'sd16 - 21'(req_q.obj_z);
  always_comb begin
    case (k_q)
      2'd0:    dk = dx;
      2'd1:    dk = dy;
      default: dk = dz;
    endcase
  end
  assign mk = dk[20] ? 21'(-dk) : dk;
  assign rm = req_q.radius[15] ? 20'(-21'(req_q.radius)) : 20'(req_q.radius);

  function automatic logic [7:0] sat8(input logic neg, input logic [DivW-1:0] q);
    logic [7:0] v;
    if (neg) v = (q > 128) ? 8'h80 : 8'(-q[8:0]);
    else     v = (q > 127) ? 8'h7f : q[7:0];
    return v;
  endfunction

  function automatic logic [7:0] chan(input logic [23:0] c, input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = c[23:16];
      2'd1:    v = c[15:8];
      default: v = c[7:0];
    endcase
    return v;
  endfunction

  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  always_comb begin
    logic [2:0] su;
    logic [7:0] dv;
    state_d = state_q; res_d = res_q; out_valid_d = out_valid_q;
    slots_d = slots_q; k_d = k_q; d2_d = d2_q; r2_d = r2_q; s_d = s_q;
    sub_d = sub_q; mcnt_d = mcnt_q;
    mul_start = 1'b0; mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_sqrt = 1'b0; div_num = '0; div_den = '0;
    su = req_q.new_group ? 3'd0 : slots_q;
    dv = '0;
    if (out_o.valid && out_o.ready) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          state_d = S_CMP; k_d = '0; d2_d = '0; sub_d = 1'b0; res_d = '0;
        end
      end
      S_CMP: begin
        res_d = '0;
        if (req_q.func) begin
          if (su >= 3'(MAX_SLOTS)) res_d.status = ST_FULL;
          else begin
            res_d.status = ST_BOUND; res_d.slot = su; slots_d = su + 3'd1;
            res_d.red = req_q.color_rgb[23:16];
            res_d.green = req_q.color_rgb[15:8];
            res_d.blue = req_q.color_rgb[7:0];
            res_d.dir_x = req_q.light_x[7:0];
            res_d.dir_y = req_q.light_y[7:0];
            res_d.dir_z = req_q.light_z[7:0];
          end
          if (req_q.new_group && su >= 3'(MAX_SLOTS)) slots_d = 3'd0;
          state_d = S_DONE;
        end else if (!req_q.position_valid) begin
          res_d.status = ST_SKIP;
          if (req_q.new_group) slots_d = 3'd0;
          state_d = S_DONE;
        end else begin
          // square |d| for each axis, then radius
          k_d = '0; sub_d = 1'b0; mcnt_d = '0; state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (!sub_q) begin
          mul_start = 1'b1;
          mul_a = (k_q == 2'd3) ? MW'(rm) : MW'(mk);
          mul_b = mul_a;
          sub_d = 1'b1; mcnt_d = 7'(MW + 1);
        end else begin
          mcnt_d = mcnt_q - 1'b1;
          if (mcnt_q == 7'd1) begin
            sub_d = 1'b0;
            if (k_q == 2'd3) begin
              r2_d = D2W'({mul_p[30:0], 8'h00});
              state_d = S_COL;
            end else begin
              d2_d = d2_q + D2W'(mul_p);
              k_d = k_q + 2'd1;
            end
          end
        end
      end
      S_COL: begin
        // in-range and fullness checks, then three colour divides
        if (!(d2_q < r2_q)) begin
          res_d.status = ST_SKIP;
          if (req_q.new_group) slots_d = 3'd0;
          state_d = S_DONE;
        end else if (su >= 3'(MAX_SLOTS)) begin
          res_d.status = ST_FULL;
          if (req_q.new_group) slots_d = 3'd0;
          state_d = S_DONE;
        end else if (!sub_q) begin
          mul_start = 1'b1;
          mul_a = MW'(chan(req_q.color_rgb, k_q == 2'd3 ? 2'd0 : k_q));
          mul_b = MW'(r2_q - d2_q);
          sub_d = 1'b1; mcnt_d = 7'(MW + 1);
          if (k_q == 2'd3) k_d = 2'd0;
        end else if (mcnt_q != '0) begin
          mcnt_d = mcnt_q - 1'b1;
          if (mcnt_q == 7'd1) begin
            div_start = 1'b1;
            div_num = DivW'(mul_p);
            div_den = MW'(r2_q);
          end
        end else if (!div_busy) begin
          case (k_q)
            2'd0:    res_d.red = div_q[7:0];
            2'd1:    res_d.green = div_q[7:0];
            default: res_d.blue = div_q[7:0];
          endcase
          sub_d = 1'b0;
          if (k_q == 2'd2) begin
            k_d = '0;
            state_d = S_SQRT;
          end else k_d = k_q + 2'd1;
        end
      end
      S_SQRT: begin
        if (d2_q < D2W'(256)) begin
          state_d = S_DIV; sub_d = 1'b0; s_d = SW'(16); mcnt_d = '0;
        end else if (!sub_q) begin
          div_start = 1'b1; div_sqrt = 1'b1;
          div_num = DivW'({d2_q, 16'h0000});
          sub_d = 1'b1;
        end else if (!div_busy) begin
          s_d = SW'(div_q); sub_d = 1'b0; state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!sub_q) begin
          div_start = 1'b1;
          div_num = (d2_q < D2W'(256)) ? DivW'(22'(mk) * 22'd120)
                                       : DivW'(NumW'(mk) * NumW'(30720));
          div_den = MW'(s_q);
          sub_d = 1'b1;
        end else if (!div_busy) begin
          dv = sat8(dk[20], div_q);
          case (k_q)
            2'd0:    res_d.dir_x = dv;
            2'd1:    res_d.dir_y = dv;
            default: res_d.dir_z = dv;
          endcase
          sub_d = 1'b0;
          if (k_q == 2'd2) begin
            res_d.status = ST_BOUND; res_d.slot = su; slots_d = su + 3'd1;
            state_d = S_DONE;
          end else k_d = k_q + 2'd1;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_valid_q <= 1'b0; slots_q <= '0;
      k_q <= '0; sub_q <= 1'b0; mcnt_q <= '0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d; slots_q <= slots_d;
      k_q <= k_d; sub_q <= sub_d; mcnt_q <= mcnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) req_q <= in_i.data;
    res_q <= res_d; d2_q <= d2_d; r2_q <= r2_d; s_q <= s_d;
  end

  `PLB_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !in_i.ready,
    "request accepted while busy")
  `PLB_ASSERT_IMP(a_slots_range, clk_i, rst_ni, 1'b1, slots_q <= 3'(MAX_SLOTS),
    "slot count beyond group size")
  `PLB_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == S_DONE, out_o.valid,
    "result not presented")
  `PLB_ASSERT_IMP(a_unbound_zero, clk_i, rst_ni,
    out_o.valid && out_o.data.status != ST_BOUND, out_o.data.slot == 3'd0,
    "unbound result carries a slot")
  `PLB_ASSERT_IMP(a_mul_done, clk_i, rst_ni, mul_done, mcnt_q == 7'd2,
    "multiplier finished out of step with its counter")
endmodule
